### src/ldpc_sparse_syndrome_macros.svh
// Assertion macros shared by the syndrome block
`ifndef LDPC_SPARSE_SYNDROME_MACROS_SVH
`define LDPC_SPARSE_SYNDROME_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define LDPCSS_CHK_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LDPCSS_CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### src/ldpcss_pkg.sv
// Shared types and constants for the sparse syndrome block
package ldpcss_pkg;

    localparam int ROW_W         = 9;
    localparam int COL_IN_W      = 10;
    localparam int SLOT_IN_W     = 2;
    localparam int SYN_WORD_W    = 64;
    localparam int BIT_IDX_W     = 6;
    localparam int WORD_IDX_W    = 3;
    localparam int SYN_WORDS_MAX = 8;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_ERROR = 2'd1,
        REQ_EMIT  = 2'd2
    } t_req_type;

    // requests into the syndrome store
    typedef struct packed {
        logic                  tog_v;
        logic [WORD_IDX_W-1:0] tog_word;
        logic [BIT_IDX_W-1:0]  tog_bit;
        logic                  emit_rd;
        logic [WORD_IDX_W-1:0] emit_word;
    } t_syn_req;

endpackage

### src/ldpcss_tbl_ram.sv
// Column support table: one write port, one registered read port
module ldpcss_tbl_ram #(
    parameter int AW = 12
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [ldpcss_pkg::ROW_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic [ldpcss_pkg::ROW_W-1:0] o_rdata
);

    localparam int DEPTH = 2 ** AW;

    logic [ldpcss_pkg::ROW_W-1:0] r_mem [DEPTH];
    logic [ldpcss_pkg::ROW_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/ldpcss_syn_store.sv
// Syndrome word store: read-toggle-write with forwarding, per-word valid bits
module ldpcss_syn_store (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ldpcss_pkg::t_syn_req              i_req,
    output logic                              o_busy,
    output logic [ldpcss_pkg::SYN_WORD_W-1:0] o_emit_data
);

    localparam int WORDS = ldpcss_pkg::SYN_WORDS_MAX;

    logic [ldpcss_pkg::SYN_WORD_W-1:0] r_mem [WORDS];
    logic [ldpcss_pkg::SYN_WORD_W-1:0] r_q;
    logic                              r_q_valid;
    logic [WORDS-1:0]                  r_word_valid;

    logic                              r_s2_v;
    logic [ldpcss_pkg::WORD_IDX_W-1:0] r_s2_word;
    logic [ldpcss_pkg::BIT_IDX_W-1:0]  r_s2_bit;

    logic                              r_fwd_v;
    logic [ldpcss_pkg::WORD_IDX_W-1:0] r_fwd_word;
    logic [ldpcss_pkg::SYN_WORD_W-1:0] r_fwd_data;

    logic                              rd_en;
    logic [ldpcss_pkg::WORD_IDX_W-1:0] rd_word;
    logic [ldpcss_pkg::SYN_WORD_W-1:0] base;
    logic [ldpcss_pkg::SYN_WORD_W-1:0] wdata;

    assign rd_en   = i_req.tog_v || i_req.emit_rd;
    assign rd_word = i_req.tog_v ? i_req.tog_word : i_req.emit_word;

    // the write of the previous cycle is not yet in the read data
    always_comb begin
        if (r_fwd_v && (r_fwd_word == r_s2_word)) begin
            base = r_fwd_data;
        end else if (r_q_valid) begin
            base = r_q;
        end else begin
            base = '0;
        end
        wdata = base ^ (ldpcss_pkg::SYN_WORD_W'(1) << r_s2_bit);
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_v) begin
            r_mem[r_s2_word] <= wdata;
        end
        if (rd_en) begin
            r_q       <= r_mem[rd_word];
            r_q_valid <= r_word_valid[rd_word];
        end
        r_s2_word  <= i_req.tog_word;
        r_s2_bit   <= i_req.tog_bit;
        r_fwd_word <= r_s2_word;
        r_fwd_data <= wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v       <= 1'b0;
            r_fwd_v      <= 1'b0;
            r_word_valid <= '0;
        end else begin
            r_s2_v  <= i_req.tog_v;
            r_fwd_v <= r_s2_v;
            if (r_s2_v) begin
                r_word_valid[r_s2_word] <= 1'b1;
            end
            // emit clears the word as it reads it
            if (i_req.emit_rd) begin
                r_word_valid[i_req.emit_word] <= 1'b0;
            end
        end
    end

    assign o_busy      = r_s2_v;
    assign o_emit_data = r_q_valid ? r_q : '0;

endmodule

### src/ldpc_sparse_syndrome.sv
// Sparse parity-check syndrome: support table load, error toggling, word emit
//
//  channel  dir  handshake               words
//  in       in   i_in_valid/o_in_stall   req_type, column, slot, row_index, error_pos
//  out      out  o_out_valid/i_out_stall syndrome_word, word_index, last
//
// Load: written in the accept cycle. Error position: the accept cycle, then one
// support table read per cycle, one per slot; the toggle pipeline behind it then drains,
// overlapped with the next request. Emit: the accept cycle, then per syndrome word a store
// read and then an output register load, after the toggle pipeline has drained; an output
// stall holds it. Reset is synchronous; syndrome words read as zero until toggled, no
// clearing pass. The support table holds nothing defined until loaded.
`include "ldpc_sparse_syndrome_macros.svh"

module ldpc_sparse_syndrome #(
    parameter int CODE_LEN   = 1024,
    parameter int REDUNDANCY = 512,
    parameter int COL_WEIGHT = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [1:0]                            i_req_type,
    input  logic [ldpcss_pkg::COL_IN_W-1:0]       i_column,
    input  logic [ldpcss_pkg::SLOT_IN_W-1:0]      i_slot,
    input  logic [ldpcss_pkg::ROW_W-1:0]          i_row_index,
    input  logic [ldpcss_pkg::COL_IN_W-1:0]       i_error_pos,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [ldpcss_pkg::SYN_WORD_W-1:0]     o_syndrome_word,
    output logic [ldpcss_pkg::WORD_IDX_W-1:0]     o_word_index,
    output logic                                  o_last
);

    localparam int TBL_COLS   = (CODE_LEN < 1024) ? CODE_LEN : 1024;
    localparam int COL_W      = $clog2(TBL_COLS);
    localparam int SLOT_W     = (COL_WEIGHT > 1) ? $clog2(COL_WEIGHT) : 1;
    localparam int TBL_AW     = COL_W + SLOT_W;
    localparam int SYN_WORDS  = (REDUNDANCY + 63) / 64;
    localparam int EMIT_WORDS = (SYN_WORDS < ldpcss_pkg::SYN_WORDS_MAX)
                                ? SYN_WORDS : ldpcss_pkg::SYN_WORDS_MAX;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ERR,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

    t_state                            r_state;
    logic [COL_W-1:0]                  r_pos;
    logic [SLOT_W-1:0]                 r_slot_cnt;
    logic                              r_s1_v;
    logic [ldpcss_pkg::WORD_IDX_W-1:0] r_emit_cnt;
    logic                              r_out_valid;
    logic [ldpcss_pkg::SYN_WORD_W-1:0] r_syndrome_word;
    logic [ldpcss_pkg::WORD_IDX_W-1:0] r_word_index;
    logic                              r_last;

    logic                              accept;
    ldpcss_pkg::t_req_type             req;
    logic [4:0]                        slot_ext;
    logic                              load_ok;
    logic                              pos_ok;
    logic                              tbl_re;
    logic [ldpcss_pkg::ROW_W-1:0]      tbl_rdata;
    logic                              row_ok;
    logic                              out_free;
    ldpcss_pkg::t_syn_req              syn_req;
    logic                              syn_busy;
    logic [ldpcss_pkg::SYN_WORD_W-1:0] emit_data;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign req        = ldpcss_pkg::t_req_type'(i_req_type);
    assign slot_ext   = {3'b000, i_slot};
    assign load_ok    = accept && (req == ldpcss_pkg::REQ_LOAD)
                        && (32'(i_column) < CODE_LEN) && (32'(i_slot) < COL_WEIGHT);
    assign pos_ok     = 32'(i_error_pos) < CODE_LEN;
    assign tbl_re     = (r_state == ST_ERR);
    assign row_ok     = 32'(tbl_rdata) < REDUNDANCY;
    assign out_free   = !r_out_valid || !i_out_stall;

    ldpcss_tbl_ram #(
        .AW(TBL_AW)
    ) u_tbl (
        .i_clk  (i_clk),
        .i_we   (load_ok),
        .i_waddr({i_column[COL_W-1:0], slot_ext[SLOT_W-1:0]}),
        .i_wdata(i_row_index),
        .i_re   (tbl_re),
        .i_raddr({r_pos, r_slot_cnt}),
        .o_rdata(tbl_rdata)
    );

    always_comb begin
        syn_req.tog_v     = r_s1_v && row_ok;
        syn_req.tog_word  = tbl_rdata[8:6];
        syn_req.tog_bit   = tbl_rdata[5:0];
        // wait for toggles in flight before reading out
        syn_req.emit_rd   = (r_state == ST_EMIT_RD) && !r_s1_v && !syn_busy;
        syn_req.emit_word = r_emit_cnt;
    end

    ldpcss_syn_store u_syn (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (syn_req),
        .o_busy     (syn_busy),
        .o_emit_data(emit_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_s1_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_v <= tbl_re;
            // a word taken while the next one loads is refilled below
            if (r_out_valid && !i_out_stall && (r_state != ST_EMIT_LD)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        case (req)
                            ldpcss_pkg::REQ_ERROR: begin
                                if (pos_ok) begin
                                    r_pos      <= i_error_pos[COL_W-1:0];
                                    r_slot_cnt <= '0;
                                    r_state    <= ST_ERR;
                                end
                            end
                            ldpcss_pkg::REQ_EMIT: begin
                                r_emit_cnt <= '0;
                                r_state    <= ST_EMIT_RD;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_ERR: begin
                    r_slot_cnt <= r_slot_cnt + SLOT_W'(1);
                    if (r_slot_cnt == SLOT_W'(COL_WEIGHT - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_EMIT_RD: begin
                    if (syn_req.emit_rd) begin
                        r_state <= ST_EMIT_LD;
                    end
                end
                ST_EMIT_LD: begin
                    if (out_free) begin
                        r_out_valid     <= 1'b1;
                        r_syndrome_word <= emit_data;
                        r_word_index    <= r_emit_cnt;
                        r_last          <= (r_emit_cnt ==
                                            ldpcss_pkg::WORD_IDX_W'(EMIT_WORDS - 1));
                        if (r_emit_cnt == ldpcss_pkg::WORD_IDX_W'(EMIT_WORDS - 1)) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_emit_cnt <= r_emit_cnt + ldpcss_pkg::WORD_IDX_W'(1);
                            r_state    <= ST_EMIT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_syndrome_word = r_syndrome_word;
    assign o_word_index    = r_word_index;
    assign o_last          = r_last;

    `LDPCSS_CHK_SAME(a_last_index, r_out_valid && r_last,
        r_word_index == ldpcss_pkg::WORD_IDX_W'(EMIT_WORDS - 1), "last flag on wrong word")
    `LDPCSS_CHK_SAME(a_no_rd_clash, syn_req.tog_v, !syn_req.emit_rd,
        "toggle and emit read in one cycle")
    `LDPCSS_CHK_NEXT(a_emit_runs, r_out_valid && !i_out_stall && !r_last,
        (r_state == ST_EMIT_RD) || (r_state == ST_EMIT_LD) || r_out_valid,
        "emit ended early")
    `LDPCSS_CHK_SAME(a_tog_src, syn_req.tog_v, $past(r_state == ST_ERR),
        "toggle without table read")

endmodule
